// ----- sv/dmwtc_pkg.sv -----
`default_nettype none

package dmwtc_pkg;

    // Fixed field widths
    localparam int ADDR_W    = 12;
    localparam int DATA_W    = 32;
    localparam int TAG_W     = 12;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;

    // Default sizing
    localparam int DEF_MAX_LINES          = 64;
    localparam int DEF_MAX_WORDS_PER_LINE = 16;
    localparam int DEF_MEM_WORDS          = 4096;

    // Compare/subtract steps that bring a 12-bit address below MEM_WORDS (>= 256)
    localparam int MOD_STEPS = ADDR_W - 8 + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 1'd1;

    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 3'd2;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 3'd4;

    // Access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] offset_bits;
        logic [CFG_W-1:0] index_bits;
    } cfg_t;

    typedef struct packed {
        logic clearing;
        logic filling;
    } stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAG,
        ST_FILL,
        ST_ACCESS,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ----- sv/dmwtc_ram.sv -----
`default_nettype none

module dmwtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/dmwtc_ctrl.sv -----
`default_nettype none

module dmwtc_ctrl
    import dmwtc_pkg::*;
#(
    parameter int MAX_LINES          = DEF_MAX_LINES,
    parameter int MAX_WORDS_PER_LINE = DEF_MAX_WORDS_PER_LINE,
    parameter int MEM_WORDS          = DEF_MEM_WORDS,
    localparam int LINE_AW           = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1,
    localparam int DATA_DEPTH        = MAX_LINES * MAX_WORDS_PER_LINE,
    localparam int DATA_AW           = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1,
    localparam int MEM_AW            = $clog2(MEM_WORDS)
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cfg_t                      cfg,
    output stat_t                          stat,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_func,
    input  wire logic [ADDR_W-1:0]         s_address,
    input  wire logic [DATA_W-1:0]         s_write_data,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic      [DATA_W-1:0]         m_read_data,
    output logic                           m_hit,

    output logic                           tag_we,
    output logic      [LINE_AW-1:0]        tag_waddr,
    output logic      [TAG_W-1:0]          tag_wdata,
    output logic                           tag_re,
    output logic      [LINE_AW-1:0]        tag_raddr,
    input  wire logic [TAG_W-1:0]          tag_rdata,

    output logic                           data_we,
    output logic      [DATA_AW-1:0]        data_waddr,
    output logic      [DATA_W-1:0]         data_wdata,
    output logic                           data_re,
    output logic      [DATA_AW-1:0]        data_raddr,
    input  wire logic [DATA_W-1:0]         data_rdata,

    output logic                           bk_we,
    output logic      [MEM_AW-1:0]         bk_waddr,
    output logic      [DATA_W-1:0]         bk_wdata,
    output logic                           bk_re,
    output logic      [MEM_AW-1:0]         bk_raddr,
    input  wire logic [DATA_W-1:0]         bk_rdata
);

    localparam int OB_MAX     = $clog2(MAX_WORDS_PER_LINE + 1) - 1;
    localparam int IB_MAX     = $clog2(MAX_LINES + 1) - 1;
    localparam int OFF_W      = (OB_MAX > 0) ? OB_MAX : 1;
    localparam int CLR_DEPTH  = (MEM_WORDS > DATA_DEPTH) ? MEM_WORDS : DATA_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam int WRAP_W     = MEM_AW + MOD_STEPS + 1;

    localparam logic [CLR_W-1:0] CLR_LAST   = CLR_W'(CLR_DEPTH - 1);
    localparam logic [CLR_W:0]   CLR_LINES  = (CLR_W + 1)'(MAX_LINES);
    localparam logic [CLR_W:0]   CLR_DWORDS = (CLR_W + 1)'(DATA_DEPTH);
    localparam logic [CLR_W:0]   CLR_MWORDS = (CLR_W + 1)'(MEM_WORDS);

    // Address modulo MEM_WORDS by binary compare/subtract
    function automatic logic [MEM_AW-1:0] mem_wrap(input logic [ADDR_W-1:0] a);
        logic [WRAP_W-1:0] r;
        logic [WRAP_W-1:0] lim;
        r = WRAP_W'(a);
        for (int i = MOD_STEPS - 1; i >= 0; i--) begin
            lim = WRAP_W'(MEM_WORDS) << i;
            if (r >= lim) begin
                r = r - lim;
            end
        end
        return r[MEM_AW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic                clr_reg;
    logic [CLR_W-1:0]    clr_cnt_reg;
    logic                func_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [DATA_W-1:0]   wdata_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [LINE_AW-1:0]  line_reg;
    logic [DATA_AW-1:0]  base_reg;
    logic [OFF_W-1:0]    omask_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [OFF_W-1:0]    k_reg;
    logic                hit_reg;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_data_reg;
    logic                m_hit_reg;

    // Address split of the incoming item
    logic [CFG_W-1:0]    ob_c, ib_c;
    logic [ADDR_W-1:0]   omask_c, imask_c, line_c, tag_c;
    logic [DATA_AW-1:0]  base_c;
    logic                accept, tag_match, fill_last, out_free;
    logic [ADDR_W-1:0]   fill_start;
    logic [OFF_W-1:0]    k_inc;

    always_comb begin
        ob_c    = (int'(cfg.offset_bits) > OB_MAX) ? CFG_W'(OB_MAX) : cfg.offset_bits;
        ib_c    = (int'(cfg.index_bits) > IB_MAX) ? CFG_W'(IB_MAX) : cfg.index_bits;
        omask_c = (ADDR_W'(1) << ob_c) - ADDR_W'(1);
        imask_c = (ADDR_W'(1) << ib_c) - ADDR_W'(1);
        line_c  = (s_address >> ob_c) & imask_c;
        tag_c   = s_address >> ({1'b0, ob_c} + {1'b0, ib_c});
        base_c  = DATA_AW'(DATA_AW'(line_c[LINE_AW-1:0]) * DATA_AW'(MAX_WORDS_PER_LINE));
    end

    assign accept     = (state_reg == ST_IDLE) && s_valid;
    assign tag_match  = (tag_rdata == tag_reg);
    assign fill_last  = (k_reg == omask_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign fill_start = addr_reg & ~ADDR_W'(omask_reg);
    assign k_inc      = k_reg + OFF_W'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_TAG;
                end
            end
            ST_TAG: begin
                state_next = tag_match ? ST_ACCESS : ST_FILL;
            end
            ST_FILL: begin
                if (fill_last) begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Memory controls and handshake
    always_comb begin
        s_ready    = 1'b0;
        tag_we     = 1'b0;
        tag_waddr  = line_reg;
        tag_wdata  = tag_reg;
        tag_re     = 1'b0;
        tag_raddr  = line_c[LINE_AW-1:0];
        data_we    = 1'b0;
        data_waddr = base_reg + DATA_AW'(off_reg);
        data_wdata = wdata_reg;
        data_re    = 1'b0;
        data_raddr = base_reg + DATA_AW'(off_reg);
        bk_we      = 1'b0;
        bk_waddr   = mem_wrap(addr_reg);
        bk_wdata   = wdata_reg;
        bk_re      = 1'b0;
        bk_raddr   = mem_wrap(fill_start | ADDR_W'(k_inc));
        unique case (state_reg)
            ST_CLEAR: begin
                tag_we     = {1'b0, clr_cnt_reg} < CLR_LINES;
                tag_waddr  = clr_cnt_reg[LINE_AW-1:0];
                tag_wdata  = '0;
                data_we    = {1'b0, clr_cnt_reg} < CLR_DWORDS;
                data_waddr = clr_cnt_reg[DATA_AW-1:0];
                data_wdata = '0;
                bk_we      = {1'b0, clr_cnt_reg} < CLR_MWORDS;
                bk_waddr   = clr_cnt_reg[MEM_AW-1:0];
                bk_wdata   = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                tag_re  = s_valid;
            end
            ST_TAG: begin
                if (!tag_match) begin
                    tag_we   = 1'b1;
                    bk_re    = 1'b1;
                    bk_raddr = mem_wrap(fill_start);
                end
            end
            ST_FILL: begin
                // word k lands while word k+1 is fetched
                data_we    = 1'b1;
                data_waddr = base_reg + DATA_AW'(k_reg);
                data_wdata = bk_rdata;
                bk_re      = !fill_last;
            end
            ST_ACCESS: begin
                if (func_reg == FUNC_WRITE) begin
                    data_we = 1'b1;
                    bk_we   = 1'b1;
                end else begin
                    data_re = 1'b1;
                end
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
                clr_reg     <= (state_next == ST_CLEAR);
            end
            if (state_reg == ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= s_func;
            addr_reg  <= s_address;
            wdata_reg <= s_write_data;
            tag_reg   <= tag_c;
            line_reg  <= line_c[LINE_AW-1:0];
            base_reg  <= base_c;
            omask_reg <= OFF_W'(omask_c);
            off_reg   <= OFF_W'(s_address & omask_c);
        end
        if (state_reg == ST_TAG) begin
            hit_reg <= tag_match;
            k_reg   <= '0;
        end
        if (state_reg == ST_FILL) begin
            k_reg <= k_inc;
        end
        if (state_reg == ST_RESP && out_free) begin
            m_data_reg <= (func_reg == FUNC_WRITE) ? wdata_reg : data_rdata;
            m_hit_reg  <= hit_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_data_reg;
    assign m_hit         = m_hit_reg;
    assign stat.clearing = clr_reg;
    assign stat.filling  = (state_reg == ST_FILL);

endmodule

`default_nettype wire

// ----- sv/direct_mapped_write_through_cache.sv -----
`default_nettype none

// Direct-mapped, write-through, write-allocate cache with its backing memory
// inside. Tag store, line data and backing memory are single-port-read
// synchronous RAMs. After reset the block runs a clearing pass over
// max(MEM_WORDS, MAX_LINES*MAX_WORDS_PER_LINE) addresses (4096 by default) with
// s_ready low; config writes are taken meanwhile. Items are handled one at a
// time: an item passes through the tag, (on a miss) refill, access and response
// states, and m_valid rises as it leaves the response state, which waits until
// the previous result is taken; the block is then idle for the next input
// transfer. The refill moves 2^offset_bits words (offset_bits saturated at log2
// of MAX_WORDS_PER_LINE), one word per cycle through the backing memory read
// port. A result waiting on m_ready does not block the next input transfer.
// Config must only change while no item is in flight.
module direct_mapped_write_through_cache
    import dmwtc_pkg::*;
#(
    parameter int MAX_LINES          = DEF_MAX_LINES,
    parameter int MAX_WORDS_PER_LINE = DEF_MAX_WORDS_PER_LINE,
    parameter int MEM_WORDS          = DEF_MEM_WORDS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_wdata,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_func,
    input  wire logic [ADDR_W-1:0]         s_address,
    input  wire logic signed [DATA_W-1:0]  s_write_data,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [DATA_W-1:0]       m_read_data,
    output logic                           m_hit
);

    localparam int LINE_AW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int DATA_DEPTH = MAX_LINES * MAX_WORDS_PER_LINE;
    localparam int DATA_AW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int MEM_AW     = $clog2(MEM_WORDS);

    cfg_t  cfg_reg;
    stat_t stat;

    logic               tag_we, tag_re;
    logic [LINE_AW-1:0] tag_waddr, tag_raddr;
    logic [TAG_W-1:0]   tag_wdata, tag_rdata;
    logic               data_we, data_re;
    logic [DATA_AW-1:0] data_waddr, data_raddr;
    logic [DATA_W-1:0]  data_wdata, data_rdata;
    logic               bk_we, bk_re;
    logic [MEM_AW-1:0]  bk_waddr, bk_raddr;
    logic [DATA_W-1:0]  bk_wdata, bk_rdata;
    logic [DATA_W-1:0]  rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_bits <= OFFSET_BITS_RST;
            cfg_reg.index_bits  <= INDEX_BITS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: cfg_reg.offset_bits <= cfg_wdata;
                CFG_INDEX_BITS:  cfg_reg.index_bits  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    dmwtc_ctrl #(
        .MAX_LINES          (MAX_LINES),
        .MAX_WORDS_PER_LINE (MAX_WORDS_PER_LINE),
        .MEM_WORDS          (MEM_WORDS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .stat         (stat),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (rd_data),
        .m_hit        (m_hit),
        .tag_we       (tag_we),
        .tag_waddr    (tag_waddr),
        .tag_wdata    (tag_wdata),
        .tag_re       (tag_re),
        .tag_raddr    (tag_raddr),
        .tag_rdata    (tag_rdata),
        .data_we      (data_we),
        .data_waddr   (data_waddr),
        .data_wdata   (data_wdata),
        .data_re      (data_re),
        .data_raddr   (data_raddr),
        .data_rdata   (data_rdata),
        .bk_we        (bk_we),
        .bk_waddr     (bk_waddr),
        .bk_wdata     (bk_wdata),
        .bk_re        (bk_re),
        .bk_raddr     (bk_raddr),
        .bk_rdata     (bk_rdata)
    );

    assign m_read_data = rd_data;

    dmwtc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (MAX_LINES)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    dmwtc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DATA_DEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    dmwtc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_backing_ram (
        .aclk  (aclk),
        .we    (bk_we),
        .waddr (bk_waddr),
        .wdata (bk_wdata),
        .re    (bk_re),
        .raddr (bk_raddr),
        .rdata (bk_rdata)
    );

`ifndef SYNTHESIS
    // clearing pass keeps the input closed
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open right after reset");

    // one item at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transfer accepted back to back");

    // write-through never coincides with a tag replacement
    a_wt_vs_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (bk_we && !stat.clearing) |-> !tag_we)
        else $error("backing write during tag update");

    a_fill_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.filling |-> (!s_ready && !bk_we))
        else $error("input open or backing write during refill");
`endif

endmodule

`default_nettype wire

// ----- test/dmwtc_access_check.sv -----
module dmwtc_access_check
    import dmwtc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_wdata,

    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic                     s_func,
    input  wire logic [ADDR_W-1:0]        s_address,
    input  wire logic signed [DATA_W-1:0] s_write_data,

    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic signed [DATA_W-1:0] m_read_data,
    input  wire logic                     m_hit,

    output int                            fail_count,
    output int                            pending
);

    // floor(log2(n))
    localparam int OFFSET_CAP = $clog2(DEF_MAX_WORDS_PER_LINE + 1) - 1;
    localparam int INDEX_CAP  = $clog2(DEF_MAX_LINES + 1) - 1;
    localparam int LINE_SLOTS = DEF_MAX_LINES * DEF_MAX_WORDS_PER_LINE;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic                     hit;
    } access_result_t;

    logic [TAG_W-1:0]  tag_copy  [DEF_MAX_LINES];
    logic [DATA_W-1:0] line_copy [LINE_SLOTS];
    logic [DATA_W-1:0] mem_copy  [DEF_MEM_WORDS];
    logic [CFG_W-1:0]  offset_bits;
    logic [CFG_W-1:0]  index_bits;
    access_result_t    awaited_results [$];
    int                mismatches;

    function automatic access_result_t predict_access(
        input logic              fn,
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] wdata
    );
        int unsigned    a;
        int unsigned    ob;
        int unsigned    ib;
        int unsigned    omask;
        int unsigned    off;
        int unsigned    line;
        int unsigned    base;
        int unsigned    start;
        logic [TAG_W-1:0] tag;
        access_result_t r;
        a     = addr;
        ob    = (offset_bits > OFFSET_CAP) ? OFFSET_CAP : offset_bits;
        ib    = (index_bits > INDEX_CAP) ? INDEX_CAP : index_bits;
        omask = (32'd1 << ob) - 1;
        off   = a & omask;
        line  = (a >> ob) & ((32'd1 << ib) - 1);
        tag   = TAG_W'(a >> (ob + ib));
        base  = line * DEF_MAX_WORDS_PER_LINE;
        r.hit = (tag_copy[line] == tag);
        if (!r.hit) begin
            // refill the aligned line, then take the new tag
            start = a & ~omask;
            for (int k = 0; k <= omask; k++)
                line_copy[base + k] = mem_copy[(start + k) % DEF_MEM_WORDS];
            tag_copy[line] = tag;
        end
        if (fn == FUNC_WRITE) begin
            line_copy[base + off]      = wdata;
            mem_copy[a % DEF_MEM_WORDS] = wdata;
        end
        r.read_data = line_copy[base + off];
        return r;
    endfunction

    always @(posedge aclk) begin
        access_result_t want;
        if (!aresetn) begin
            foreach (tag_copy[i]) tag_copy[i] = '0;
            foreach (line_copy[i]) line_copy[i] = '0;
            foreach (mem_copy[i]) mem_copy[i] = '0;
            offset_bits = OFFSET_BITS_RST;
            index_bits  = INDEX_BITS_RST;
            awaited_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OFFSET_BITS: offset_bits = cfg_wdata;
                    CFG_INDEX_BITS:  index_bits  = cfg_wdata;
                    default: ;
                endcase
            end
            // result side first: a result can never belong to an item taken at the same edge
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result transfer: read_data %0d, hit %0b",
                           m_read_data, m_hit);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_read_data !== want.read_data) begin
                        $error("read_data: expected %0d, actual %0d",
                               want.read_data, m_read_data);
                        mismatches++;
                    end
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %0b, actual %0b", want.hit, m_hit);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(predict_access(s_func, s_address, s_write_data));
        end
        fail_count <= mismatches;
        pending    <= awaited_results.size();
    end

endmodule

// ----- test/tb_direct_mapped_write_through_cache.sv -----
module tb_direct_mapped_write_through_cache;
    import dmwtc_pkg::*;

    localparam int PHASES           = 10;
    localparam int ITEMS_PER_PHASE  = 190;
    // per-phase split, phase 0 in the low bits
    localparam logic [CFG_W*PHASES-1:0] OFFSET_PLAN =
        {3'd6, 3'd3, 3'd1, 3'd5, 3'd4, 3'd0, 3'd4, 3'd7, 3'd0, 3'd2};
    localparam logic [CFG_W*PHASES-1:0] INDEX_PLAN =
        {3'd1, 3'd5, 3'd2, 3'd3, 3'd0, 3'd6, 3'd6, 3'd7, 3'd0, 3'd4};

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_func;
    logic [ADDR_W-1:0]        s_address;
    logic signed [DATA_W-1:0] s_write_data;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_read_data;
    logic                     m_hit;

    int                fail_count;
    int                pending;
    bit                quiet;
    logic [ADDR_W-1:0] hot_addr [8];
    logic [ADDR_W-1:0] prev_addr;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    direct_mapped_write_through_cache dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_hit        (m_hit)
    );

    dmwtc_access_check access_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_hit        (m_hit),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    task automatic drive_access(
        input logic              fn,
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] data
    );
        if (!quiet && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= fn;
        s_address    <= addr;
        s_write_data <= data;
        do @(posedge aclk); while (!s_ready);
        prev_addr = addr;
    endtask

    // drain all outstanding accesses, then write both split registers
    task automatic apply_config(input logic [CFG_W-1:0] off, input logic [CFG_W-1:0] idx);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_OFFSET_BITS;
        cfg_wdata <= off;
        @(posedge aclk);
        cfg_index <= CFG_INDEX_BITS;
        cfg_wdata <= idx;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly reuse of a small address pool so lines get hit, evicted and refilled
    task automatic drive_random();
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 55)
            addr = hot_addr[$urandom_range(7)] ^ ADDR_W'($urandom_range(3));
        else if (pick < 70)
            addr = prev_addr + 1'b1;
        else
            addr = ADDR_W'($urandom);
        if ($urandom_range(7) == 0)
            hot_addr[$urandom_range(7)] = addr;
        case ($urandom_range(9))
            0:       data = '0;
            1:       data = '1;
            2:       data = 32'h8000_0000;
            3:       data = 32'h7fff_ffff;
            default: data = $urandom;
        endcase
        drive_access($urandom_range(1) ? FUNC_WRITE : FUNC_READ, addr, data);
    endtask

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_OFFSET_BITS;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_func       <= FUNC_READ;
        s_address    <= '0;
        s_write_data <= '0;
        quiet     = 1'b0;
        prev_addr = '0;
        foreach (hot_addr[i]) hot_addr[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // default split: zero tags match right after reset
        apply_config(OFFSET_BITS_RST, INDEX_BITS_RST);
        drive_access(FUNC_READ,  12'd0,    32'h0);
        drive_access(FUNC_WRITE, 12'd0,    32'h7fff_ffff);
        drive_access(FUNC_READ,  12'd0,    32'h0);
        drive_access(FUNC_WRITE, 12'd4095, 32'h8000_0000);
        drive_access(FUNC_READ,  12'd4095, 32'h0);
        drive_access(FUNC_READ,  12'd4092, 32'hffff_ffff);
        drive_access(FUNC_WRITE, 12'd64,   32'hffff_ffff);
        // evicted line comes back with the written-through word
        drive_access(FUNC_READ,  12'd0,    32'h0);
        drive_access(FUNC_READ,  12'd65,   32'h0);
        drive_access(FUNC_WRITE, 12'haaa,  32'h5555_5555);
        drive_access(FUNC_WRITE, 12'h555,  32'haaaa_aaaa);
        drive_access(FUNC_READ,  12'haaa,  32'h0);
        drive_access(FUNC_READ,  12'h555,  32'h0);
        drive_access(FUNC_WRITE, 12'd0,    32'h0);

        // new split over the old contents, no flush
        apply_config(3'd0, 3'd0);
        drive_access(FUNC_READ,  12'd64,   32'h0);
        drive_access(FUNC_READ,  12'd64,   32'h0);
        drive_access(FUNC_WRITE, 12'd4095, 32'h0000_0001);
        drive_access(FUNC_READ,  12'd4094, 32'h0);

        // oversized fields saturate
        apply_config(3'd7, 3'd7);
        drive_access(FUNC_READ,  12'd4095, 32'h0);
        drive_access(FUNC_READ,  12'd4080, 32'h0);
        drive_access(FUNC_WRITE, 12'd1024, 32'h1234_5678);
        drive_access(FUNC_READ,  12'd1039, 32'h0);

        for (int phase = 0; phase < PHASES; phase++) begin
            apply_config(OFFSET_PLAN[phase*CFG_W +: CFG_W], INDEX_PLAN[phase*CFG_W +: CFG_W]);
            quiet = (phase == PHASES - 1) || ($urandom_range(3) == 0);
            foreach (hot_addr[i]) hot_addr[i] = ADDR_W'($urandom);
            repeat (ITEMS_PER_PHASE) drive_random();
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
